### design/assert_macros.svh
// Assertion macros shared by the RTL of the quad overlap test.
// Depends on nothing; the including module provides aclk and aresetn.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside of reset.
`define SQC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every rising edge, reset cycles included.
`define SQC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

### design/sqc_pkg.sv
// Constants and widths for the separating-axis quad overlap test.
// Depends on nothing; imported by sat_quad_collision.
`timescale 1ns / 1ps

package sqc_pkg;

    localparam int VERTICES    = 4;
    localparam int COORD_WIDTH = 16;

    localparam int IN_COORD_W  = 16;
    localparam int IDX_W       = 2;
    localparam int STORE_DEPTH = 2 * VERTICES;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int EDGE_W      = COORD_WIDTH + 1;
    localparam int PROD_W      = COORD_WIDTH + EDGE_W;
    localparam int DOT_W       = PROD_W + 1;
    localparam int VCMP_W      = $clog2(VERTICES + 1);

    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 8;

    localparam int STATE_W     = 4;

endpackage

### design/sat_quad_collision.sv
// Top level of the separating-axis overlap test for two convex quads.
// Depends on sqc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------------------
//  s_      | in  | s_tvalid/s_tready  | tdata vertex, tuser quad, tlast run test
//  m_      | out | m_tvalid/m_tready  | tdata collide flag
//
// A vertex request that is not marked last is written to the store and the block
// stays ready for the next one. A last request starts the test: for each of the
// 2*VERTICES axes the block reads the two vertices of its edge and forms the edge
// normal, projects every vertex of both quads through the one shared multiplier
// (x product, y product, sum, interval update) and then decides, so the input
// stays not ready for the whole test, which ends early when an axis separates the
// quads. A result waits in the output register while m_tready is low; the test
// then holds in its final state until the register is free. Reset is
// synchronous and active low; the vertex store is not cleared by it.

module sat_quad_collision
    import sqc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [1:0] vertex_index, [17:2] vertex_x, [33:18] vertex_y, [39:34] zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [0] quad_sel
    input  logic                 s_tuser,
    input  logic                 s_tlast,

    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [0] collide, [7:1] zero
    output logic [M_TDATA_W-1:0] m_tdata
);

    // Sequencer states.
    localparam logic [STATE_W-1:0] S_IDLE   = 4'd0;
    localparam logic [STATE_W-1:0] S_RDA    = 4'd1;
    localparam logic [STATE_W-1:0] S_RDB    = 4'd2;
    localparam logic [STATE_W-1:0] S_AXIS   = 4'd3;
    localparam logic [STATE_W-1:0] S_MULX   = 4'd4;
    localparam logic [STATE_W-1:0] S_MULY   = 4'd5;
    localparam logic [STATE_W-1:0] S_ACC    = 4'd6;
    localparam logic [STATE_W-1:0] S_CMP    = 4'd7;
    localparam logic [STATE_W-1:0] S_DECIDE = 4'd8;
    localparam logic [STATE_W-1:0] S_OUT    = 4'd9;

    localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(STORE_DEPTH - 1);
    localparam logic [ADDR_W-1:0] QUAD1_BASE = ADDR_W'(VERTICES);
    localparam logic [ADDR_W-1:0] EDGE_WRAP  = ADDR_W'(VERTICES - 1);

    // Input fields.
    logic [IDX_W-1:0]             in_idx;
    logic signed [IN_COORD_W-1:0] in_x;
    logic signed [IN_COORD_W-1:0] in_y;
    logic signed [COORD_WIDTH-1:0] wr_x;
    logic signed [COORD_WIDTH-1:0] wr_y;
    logic [ADDR_W-1:0]            wr_addr;
    logic                         wr_en;
    logic                         in_fire;

    assign in_idx  = s_tdata[IDX_W-1:0];
    assign in_x    = s_tdata[IDX_W +: IN_COORD_W];
    assign in_y    = s_tdata[IDX_W + IN_COORD_W +: IN_COORD_W];
    // Sign extend or wrap the 16-bit input to the stored coordinate width.
    assign wr_x    = COORD_WIDTH'(in_x);
    assign wr_y    = COORD_WIDTH'(in_y);
    assign in_fire = s_tvalid && s_tready;
    // An index beyond the quad writes nothing.
    assign wr_en   = in_fire && ({{(VCMP_W - IDX_W){1'b0}}, in_idx} < VCMP_W'(VERTICES));
    assign wr_addr = ADDR_W'(s_tuser ? (VERTICES + int'(in_idx)) : int'(in_idx));

    // Vertex store, one entry per vertex of both quads, registered read.
    logic signed [COORD_WIDTH-1:0] x_mem [STORE_DEPTH];
    logic signed [COORD_WIDTH-1:0] y_mem [STORE_DEPTH];
    logic signed [COORD_WIDTH-1:0] rd_x_reg;
    logic signed [COORD_WIDTH-1:0] rd_y_reg;
    logic [ADDR_W-1:0]             rd_addr;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            x_mem[wr_addr] <= wr_x;
            y_mem[wr_addr] <= wr_y;
        end
        rd_x_reg <= x_mem[rd_addr];
        rd_y_reg <= y_mem[rd_addr];
    end

    // Sequencer and datapath registers.
    logic [STATE_W-1:0] state_reg, state_next;
    logic [ADDR_W-1:0]  axis_reg, axis_next;
    logic [ADDR_W-1:0]  vtx_reg, vtx_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic               collide_reg, collide_next;

    logic signed [COORD_WIDTH-1:0] xa_reg, ya_reg;
    logic signed [EDGE_W-1:0]      ax_reg, ay_reg;
    logic signed [PROD_W-1:0]      p_reg, sum_reg;
    logic signed [DOT_W-1:0]       dot_reg;
    logic signed [DOT_W-1:0]       min0_reg, max0_reg, min1_reg, max1_reg;

    // Second vertex of the current edge, wrapping inside its own quad.
    logic [ADDR_W-1:0] edge_b;
    logic              axis_wraps;
    assign axis_wraps = (axis_reg == EDGE_WRAP) || (axis_reg == LAST_ADDR);
    assign edge_b     = axis_wraps ? (axis_reg - EDGE_WRAP) : (axis_reg + 1'b1);

    always_comb begin
        unique case (state_reg)
            S_RDA:   rd_addr = axis_reg;
            S_RDB:   rd_addr = edge_b;
            S_CMP:   rd_addr = vtx_reg + 1'b1;
            default: rd_addr = vtx_reg;
        endcase
    end

    // The one shared multiplier: x times the axis x, then y times the axis y.
    logic signed [COORD_WIDTH-1:0] mul_a;
    logic signed [EDGE_W-1:0]      mul_b;
    logic signed [PROD_W-1:0]      prod;
    assign mul_a = (state_reg == S_MULX) ? rd_x_reg : rd_y_reg;
    assign mul_b = (state_reg == S_MULX) ? ax_reg : ay_reg;
    assign prod  = mul_a * mul_b;

    // Projection bookkeeping for the vertex now in dot_reg.
    logic in_quad1, first_of_quad, separated;
    assign in_quad1      = (vtx_reg >= QUAD1_BASE);
    assign first_of_quad = (vtx_reg == '0) || (vtx_reg == QUAD1_BASE);
    assign separated     = !((max1_reg >= min0_reg) && (max0_reg >= min1_reg));

    always_comb begin
        state_next    = state_reg;
        axis_next     = axis_reg;
        vtx_next      = vtx_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        collide_next  = collide_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_fire && s_tlast) begin
                    axis_next  = '0;
                    state_next = S_RDA;
                end
            end
            S_RDA: begin
                vtx_next   = '0;
                state_next = S_RDB;
            end
            S_RDB:  state_next = S_AXIS;
            S_AXIS: state_next = S_MULX;
            S_MULX: state_next = S_MULY;
            S_MULY: state_next = S_ACC;
            S_ACC:  state_next = S_CMP;
            S_CMP: begin
                if (vtx_reg == LAST_ADDR) begin
                    state_next = S_DECIDE;
                end else begin
                    vtx_next   = vtx_reg + 1'b1;
                    state_next = S_MULX;
                end
            end
            S_DECIDE: begin
                priority if (separated) begin
                    state_next = S_OUT;
                end else if (axis_reg == LAST_ADDR) begin
                    state_next = S_OUT;
                end else begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = S_RDA;
                end
            end
            S_OUT: begin
                // The intervals of the deciding axis stay put here, so the verdict
                // is taken only once the previous result has left.
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    collide_next  = !separated;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            axis_reg     <= '0;
            vtx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            axis_reg     <= axis_next;
            vtx_reg      <= vtx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge aclk) begin
        collide_reg <= collide_next;
        unique case (state_reg)
            S_RDB: begin
                xa_reg <= rd_x_reg;
                ya_reg <= rd_y_reg;
            end
            S_AXIS: begin
                // Edge normal (-(yb - ya), xb - xa).
                ax_reg <= EDGE_W'(ya_reg) - EDGE_W'(rd_y_reg);
                ay_reg <= EDGE_W'(rd_x_reg) - EDGE_W'(xa_reg);
            end
            S_MULX: p_reg <= prod;
            S_MULY: begin
                sum_reg <= p_reg;
                p_reg   <= prod;
            end
            S_ACC: dot_reg <= DOT_W'(sum_reg) + DOT_W'(p_reg);
            S_CMP: begin
                if (in_quad1) begin
                    if (first_of_quad || dot_reg < min1_reg) min1_reg <= dot_reg;
                    if (first_of_quad || dot_reg > max1_reg) max1_reg <= dot_reg;
                end else begin
                    if (first_of_quad || dot_reg < min0_reg) min0_reg <= dot_reg;
                    if (first_of_quad || dot_reg > max0_reg) max0_reg <= dot_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - 1){1'b0}}, collide_reg};

    // A last vertex request always starts a test on the next cycle.
    `SQC_ASSERT(a_last_starts, (s_tvalid && s_tready && s_tlast) |=> (state_reg == S_RDA), "last request did not start the test")
    // A new result only appears from the output state.
    `SQC_ASSERT(a_result_src, $rose(m_tvalid_reg) |-> ($past(state_reg) == S_OUT), "result raised outside the output state")
    // A finished test with a free output register must deliver its result.
    `SQC_ASSERT(a_result_load, ((state_reg == S_OUT) && (!m_tvalid_reg || m_tready)) |=> (m_tvalid_reg && (state_reg == S_IDLE)), "finished test did not load the output register")
    // Reset leaves the block idle with no pending result.
    `SQC_ASSERT_ALWAYS(a_reset_clear, !aresetn |=> (!m_tvalid_reg && (state_reg == S_IDLE)), "reset did not clear control state")

endmodule

### tb/sv/sat_quad_collision_tb.sv
// Self-checking testbench for sat_quad_collision: streams vertex requests, predicts each
// overlap verdict with a separating-axis model of its own and compares the results.
// Depends on sqc_pkg and the sat_quad_collision RTL.
`timescale 1ns / 1ps

module sat_quad_collision_tb;
    import sqc_pkg::*;

    typedef struct {
        bit                          quad;
        bit [IDX_W-1:0]              index;
        bit signed [IN_COORD_W-1:0]  x;
        bit signed [IN_COORD_W-1:0]  y;
        bit                          last;
        int                          gap;    // idle cycles before the request is offered
        bit                          drain;  // hold the request until no verdict is owed
    } vertex_req_t;

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = 1'b0;
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    vertex_req_t vertex_q[$];
    bit          collide_q[$];
    int          tests_owed = 0;
    int          mismatches = 0;
    bit          stim_busy  = 1'b1;

    // Predictor copy of the vertex store, indexed quad * VERTICES + vertex.
    bit signed [COORD_WIDTH-1:0] vx [STORE_DEPTH];
    bit signed [COORD_WIDTH-1:0] vy [STORE_DEPTH];

    // Shapes under construction by the stimulus generator, before clamping.
    int shape_x [STORE_DEPTH];
    int shape_y [STORE_DEPTH];
    bit tx_calm;
    bit drain_next;

    sat_quad_collision dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

    // ---------------------------------------------------------------- prediction

    // Interval of one quad's vertices projected onto the axis (ax, ay).
    function automatic void quad_span(input int q, input longint ax, input longint ay,
                                      output longint lo, output longint hi);
        longint d;
        lo = 0;
        hi = 0;
        for (int k = 0; k < VERTICES; k++) begin
            d = longint'(vx[q * VERTICES + k]) * ax + longint'(vy[q * VERTICES + k]) * ay;
            if (k == 0 || d < lo) lo = d;
            if (k == 0 || d > hi) hi = d;
        end
    endfunction

    // Every edge normal of both quads is tried as a separating axis; touching
    // intervals do not separate.
    function automatic bit quads_collide();
        longint ax, ay, lo0, hi0, lo1, hi1;
        int     a, b;
        for (int q = 0; q < 2; q++) begin
            for (int i = 0; i < VERTICES; i++) begin
                a  = q * VERTICES + i;
                b  = q * VERTICES + (i + 1) % VERTICES;
                ax = -(longint'(vy[b]) - longint'(vy[a]));
                ay = longint'(vx[b]) - longint'(vx[a]);
                quad_span(q, ax, ay, lo0, hi0);
                quad_span(1 - q, ax, ay, lo1, hi1);
                if (!(hi1 >= lo0 && hi0 >= lo1)) return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic int rand_span(input int lo, input int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    task automatic add_vertex(input int q, input int idx, input int x, input int y,
                              input bit last);
        vertex_req_t r;
        if (x > 32767) x = 32767; else if (x < -32768) x = -32768;
        if (y > 32767) y = 32767; else if (y < -32768) y = -32768;
        r.quad  = q[0];
        r.index = idx[IDX_W-1:0];
        r.x     = x[IN_COORD_W-1:0];
        r.y     = y[IN_COORD_W-1:0];
        r.last  = last;
        r.gap   = tx_calm ? 0 : $urandom_range(0, 12);
        r.drain = drain_next;
        drain_next = 1'b0;
        vertex_q = {vertex_q, r};
    endtask

    // Parallelogram c+u+w, c-u+w, c-u-w, c+u-w in winding order.
    task automatic make_quad(input int q, input int cx, input int cy,
                             input int ux, input int uy, input int wx, input int wy);
        int e;
        e = q * VERTICES;
        shape_x[e]     = cx + ux + wx;  shape_y[e]     = cy + uy + wy;
        shape_x[e + 1] = cx - ux + wx;  shape_y[e + 1] = cy - uy + wy;
        shape_x[e + 2] = cx - ux - wx;  shape_y[e + 2] = cy - uy - wy;
        shape_x[e + 3] = cx + ux - wx;  shape_y[e + 3] = cy + uy - wy;
    endtask

    // Writes the vertices of quads first_q..last_q, optionally in shuffled order,
    // and marks the final request last so that it starts the test.
    task automatic emit_quads(input int first_q, input int last_q, input bit shuffled);
        int order [STORE_DEPTH];
        int count, j, t;
        count = (last_q - first_q + 1) * VERTICES;
        for (int i = 0; i < count; i++) order[i] = first_q * VERTICES + i;
        if (shuffled) begin
            for (int i = count - 1; i > 0; i--) begin
                j        = $urandom_range(0, i);
                t        = order[i];
                order[i] = order[j];
                order[j] = t;
            end
        end
        for (int i = 0; i < count; i++)
            add_vertex(order[i] / VERTICES, order[i] % VERTICES,
                       shape_x[order[i]], shape_y[order[i]], i == count - 1);
    endtask

    // ---------------------------------------------------------------- driver

    vertex_req_t cur;
    bit          armed;
    int          gap_left;
    bit          drain_wait;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            armed    = 1'b0;
            gap_left = 0;
        end else begin
            // The slot is free unless a request is being held against a low s_tready.
            if (!s_tvalid || s_tready) begin
                if (!armed && vertex_q.size() != 0) begin
                    cur      = vertex_q.pop_front();
                    gap_left = cur.gap;
                    armed    = 1'b1;
                end
                // A last request accepted at this edge is not yet in tests_owed.
                drain_wait = armed && cur.drain && (tests_owed != 0 || (s_tvalid && s_tlast));
                if (armed && gap_left == 0 && !drain_wait) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= S_TDATA_W'({cur.y, cur.x, cur.index});
                    s_tuser  <= cur.quad;
                    s_tlast  <= cur.last;
                    armed    = 1'b0;
                end else begin
                    s_tvalid <= 1'b0;
                    if (armed && gap_left > 0) gap_left--;
                end
            end
        end
        stim_busy <= armed || vertex_q.size() != 0;
    end

    // ---------------------------------------------------------------- monitor

    int hold_left;
    int rx_calm_left;
    int owed_next;
    int entry;
    bit want;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready     <= 1'b0;
            tests_owed   <= 0;
            hold_left    = 0;
            rx_calm_left = 0;
        end else begin
            owed_next = tests_owed;

            // Results are checked before this edge's request is applied: a verdict
            // leaving now always belongs to an earlier test.
            if (m_tvalid && m_tready) begin
                if (collide_q.size() == 0) begin
                    $error("collide: no verdict expected, got %0b", m_tdata[0]);
                    mismatches++;
                end else begin
                    want = collide_q.pop_front();
                    owed_next--;
                    if (m_tdata[0] !== want) begin
                        $error("collide: expected %0b, got %0b", want, m_tdata[0]);
                        mismatches++;
                    end
                end
                // Stall for the next verdict, with calm stretches now and then.
                if (rx_calm_left > 0) begin
                    rx_calm_left--;
                    hold_left = 0;
                end else if ($urandom_range(0, 7) == 0) begin
                    rx_calm_left = $urandom_range(4, 12);
                    hold_left    = 0;
                end else begin
                    hold_left = $urandom_range(0, 12);
                end
            end else if (m_tvalid && hold_left > 0) begin
                hold_left--;
            end

            if (s_tvalid && s_tready) begin
                entry = int'(s_tuser) * VERTICES + int'(s_tdata[IDX_W-1:0]);
                if (int'(s_tdata[IDX_W-1:0]) < VERTICES) begin
                    vx[entry] = $signed(s_tdata[IDX_W +: IN_COORD_W]);
                    vy[entry] = $signed(s_tdata[IDX_W + IN_COORD_W +: IN_COORD_W]);
                end
                if (s_tlast) begin
                    collide_q = {collide_q, quads_collide()};
                    owed_next++;
                end
            end

            tests_owed <= owed_next;
            m_tready   <= (hold_left == 0);
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        int s, cx, cy, a, b, a2, d, q, kind, n, seq;
        bit across_x;

        foreach (vx[i]) begin
            vx[i] = '0;
            vy[i] = '0;
        end
        tx_calm    = 1'b0;
        drain_next = 1'b0;

        // Outer quad clamped to the full coordinate range around a small inner one.
        make_quad(0, 0, 0, 40000, 0, 0, 40000);
        make_quad(1, 0, 0, 16, 0, 0, 16);
        emit_quads(0, 1, 1'b0);
        // Two squares sharing an edge: touching counts as a collision.
        make_quad(0, 80, 80, 80, 0, 0, 80);
        make_quad(1, 240, 80, 80, 0, 0, 80);
        emit_quads(0, 1, 1'b0);
        // One unit apart: the shared normal now separates them.
        make_quad(1, 241, 80, 80, 0, 0, 80);
        emit_quads(1, 1, 1'b0);
        // Second quad collapsed to a point inside the first: all its edges have zero length.
        make_quad(1, 80, 80, 0, 0, 0, 0);
        emit_quads(1, 1, 1'b0);

        s   = 80;
        cx  = 80;
        cy  = 80;
        seq = 0;
        while (vertex_q.size() < 1040) begin
            seq++;
            tx_calm = ($urandom_range(0, 3) == 0);
            if (seq % 25 == 1) drain_next = 1'b1;
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                case ($urandom_range(0, 3))
                    0: s = 16;
                    1: s = 256;
                    2: s = 4096;
                    default: s = 6000;
                endcase
                cx = rand_span(-(32767 - 4 * s), 32767 - 4 * s);
                cy = rand_span(-(32767 - 4 * s), 32767 - 4 * s);
            end
            if (kind < 55) begin
                // Two random parallelograms near each other, written in any order.
                make_quad(0, cx, cy, rand_span(-s, s), rand_span(-s, s),
                          rand_span(-s, s), rand_span(-s, s));
                make_quad(1, cx + rand_span(-2 * s, 2 * s), cy + rand_span(-2 * s, 2 * s),
                          rand_span(-s, s), rand_span(-s, s),
                          rand_span(-s, s), rand_span(-s, s));
                emit_quads(0, 1, 1'b1);
            end else if (kind < 70) begin
                // Axis-aligned boxes whose facing sides overlap, touch or miss by one.
                a        = rand_span(1, s);
                b        = rand_span(1, s);
                a2       = rand_span(1, s);
                d        = rand_span(-1, 1);
                across_x = $urandom_range(0, 1);
                make_quad(0, cx, cy, a, 0, 0, b);
                if (across_x)
                    make_quad(1, cx + a + d + a2, cy + rand_span(-2 * b, 2 * b), a2, 0, 0, b);
                else
                    make_quad(1, cx + rand_span(-2 * a, 2 * a), cy + b + d + a2, a, 0, 0, a2);
                emit_quads(0, 1, 1'b0);
            end else if (kind < 85) begin
                // Move one quad while the other keeps its stored vertices.
                q = $urandom_range(0, 1);
                make_quad(q, cx + rand_span(-2 * s, 2 * s), cy + rand_span(-2 * s, 2 * s),
                          rand_span(-s, s), rand_span(-s, s),
                          rand_span(-s, s), rand_span(-s, s));
                emit_quads(q, q, 1'b1);
            end else begin
                // Stray vertices anywhere in range, some of them starting a test.
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    add_vertex($urandom_range(0, 1), $urandom_range(0, 3),
                               rand_span(-32768, 32767), rand_span(-32768, 32767),
                               $urandom_range(0, 3) == 0);
            end
        end
        tx_calm = 1'b0;
        make_quad(0, 0, 0, 100, 0, 0, 100);
        make_quad(1, 150, 0, 100, 0, 0, 100);
        emit_quads(0, 1, 1'b1);

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        do @(posedge aclk); while (stim_busy || s_tvalid || tests_owed != 0);
        // Room for a late or spurious verdict to show up.
        repeat (300) @(posedge aclk);

        if (mismatches == 0 && collide_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
